// ----- rtl/wpda_pkg.sv -----
// Shared widths, types and register indexes for the windowed peak detector.
package wpda_pkg;

    localparam int VOLT_W     = 16;
    localparam int CURR_W     = 24;
    localparam int AREA_W     = 52;
    localparam int MAGSUM_W   = CURR_W + 1;
    localparam int DV_W       = VOLT_W + 1;
    localparam int TERM_W     = MAGSUM_W + 1 + DV_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = CURR_W;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t CFG_WINDOW_LOW  = 2'd0;
    localparam cfg_idx_t CFG_WINDOW_HIGH = 2'd1;
    localparam cfg_idx_t CFG_THRESHOLD   = 2'd2;

    localparam logic signed [VOLT_W-1:0] WINDOW_LOW_RESET  = 16'sd0;
    localparam logic signed [VOLT_W-1:0] WINDOW_HIGH_RESET = 16'sd250;
    localparam logic [CURR_W-1:0]        THRESHOLD_RESET   = '0;

    localparam logic signed [AREA_W-1:0] AREA_MAX = {1'b0, {(AREA_W-1){1'b1}}};
    localparam logic signed [AREA_W-1:0] AREA_MIN = {1'b1, {(AREA_W-1){1'b0}}};

    typedef struct packed {
        logic signed [VOLT_W-1:0] voltage;
        logic signed [CURR_W-1:0] current;
        logic                     last;
    } sample_t;

    typedef struct packed {
        logic                     in_window;
        logic [CURR_W-1:0]        magnitude;
        logic signed [VOLT_W-1:0] voltage;
        logic signed [TERM_W-1:0] term;
        logic                     last;
    } term_t;

    typedef struct packed {
        logic signed [VOLT_W-1:0] window_low;
        logic signed [VOLT_W-1:0] window_high;
        logic [CURR_W-1:0]        threshold;
    } cfg_t;

endpackage

// ----- rtl/wpda_if.sv -----
// Request channels of the windowed peak detector: samples, results, register writes.
interface wpda_sample_if import wpda_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [VOLT_W-1:0] sample_voltage;
    logic signed [CURR_W-1:0] sample_current;
    logic                     last_sample;

    modport source (output valid, sample_voltage, sample_current, last_sample, input ready);
    modport sink   (input valid, sample_voltage, sample_current, last_sample, output ready);
endinterface

interface wpda_result_if import wpda_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic                     detected;
    logic [CURR_W-1:0]        peak_height;
    logic signed [VOLT_W-1:0] peak_voltage;
    logic signed [AREA_W-1:0] area_doubled;

    modport source (output valid, detected, peak_height, peak_voltage, area_doubled,
                    input ready);
    modport sink   (input valid, detected, peak_height, peak_voltage, area_doubled,
                    output ready);
endinterface

interface wpda_cfg_if import wpda_pkg::*; ();
    logic                  valid;
    logic                  ready;
    cfg_idx_t              index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/wpda_front.sv -----
// Window test, magnitude and trapezoid term stage, with the previous-sample state.
module wpda_front import wpda_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  logic    a_take,
    input  sample_t a_data,
    input  logic    b_take,
    output logic    b_valid,
    output term_t   b_data
);

    logic signed [VOLT_W-1:0] prev_voltage_reg, prev_voltage_next;
    logic [CURR_W-1:0]        prev_mag_reg, prev_mag_next;
    logic                     started_reg, started_next;
    logic                     b_valid_reg, b_valid_next;
    term_t                    b_reg, b_next;

    logic [CURR_W-1:0]          magnitude;
    logic                       in_window;
    logic [MAGSUM_W-1:0]        mag_sum;
    logic signed [DV_W-1:0]     dv;
    logic signed [TERM_W-1:0]   product;

    always_comb
    begin
        magnitude = a_data.current[CURR_W-1] ? (~a_data.current + 1'b1) : a_data.current;
        in_window = (a_data.voltage >= cfg.window_low) && (a_data.voltage <= cfg.window_high);
        mag_sum   = {1'b0, magnitude} + {1'b0, prev_mag_reg};
        dv        = {a_data.voltage[VOLT_W-1], a_data.voltage}
                  - {prev_voltage_reg[VOLT_W-1], prev_voltage_reg};
        product   = TERM_W'($signed({1'b0, mag_sum}) * dv);

        b_next.in_window = in_window;
        b_next.magnitude = magnitude;
        b_next.voltage   = a_data.voltage;
        b_next.term      = (in_window && started_reg) ? product : '0;
        b_next.last      = a_data.last;

        prev_voltage_next = prev_voltage_reg;
        prev_mag_next     = prev_mag_reg;
        started_next      = started_reg;
        if (a_take)
        begin
            if (in_window)
            begin
                prev_voltage_next = a_data.voltage;
                prev_mag_next     = magnitude;
                started_next      = 1'b1;
            end
            if (a_data.last)
            begin
                prev_voltage_next = '0;
                prev_mag_next     = '0;
                started_next      = 1'b0;
            end
        end

        if (a_take)
            b_valid_next = 1'b1;
        else if (b_take)
            b_valid_next = 1'b0;
        else
            b_valid_next = b_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_voltage_reg <= '0;
            prev_mag_reg     <= '0;
            started_reg      <= 1'b0;
            b_valid_reg      <= 1'b0;
        end
        else
        begin
            prev_voltage_reg <= prev_voltage_next;
            prev_mag_reg     <= prev_mag_next;
            started_reg      <= started_next;
            b_valid_reg      <= b_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_take)
            b_reg <= b_next;
    end

    assign b_valid = b_valid_reg;
    assign b_data  = b_reg;

endmodule

// ----- rtl/wpda_accum.sv -----
// Peak tracking, saturating area sum and the result register.
module wpda_accum import wpda_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  cfg_t  cfg,
    input  logic  b_valid,
    input  term_t b_data,
    output logic  b_take,
    wpda_result_if.source result
);

    logic [CURR_W-1:0]        max_mag_reg, max_mag_next;
    logic signed [VOLT_W-1:0] max_voltage_reg, max_voltage_next;
    logic                     peak_seen_reg, peak_seen_next;
    logic signed [AREA_W-1:0] area_reg, area_next;

    logic                     res_valid_reg, res_valid_next;
    logic                     res_detected_reg, res_detected_next;
    logic [CURR_W-1:0]        res_height_reg, res_height_next;
    logic signed [VOLT_W-1:0] res_voltage_reg, res_voltage_next;
    logic signed [AREA_W-1:0] res_area_reg, res_area_next;

    logic signed [AREA_W:0]   sum;
    logic                     out_free;
    logic                     detect;

    always_comb
    begin
        out_free = !res_valid_reg || result.ready;
        b_take   = b_valid && (!b_data.last || out_free);

        sum = {area_reg[AREA_W-1], area_reg}
            + (AREA_W+1)'(b_data.term);

        max_mag_next     = max_mag_reg;
        max_voltage_next = max_voltage_reg;
        peak_seen_next   = peak_seen_reg;
        area_next        = area_reg;
        if (b_data.in_window)
        begin
            if (b_data.magnitude > max_mag_reg)
            begin
                max_mag_next     = b_data.magnitude;
                max_voltage_next = b_data.voltage;
                peak_seen_next   = 1'b1;
            end
            if (sum[AREA_W] != sum[AREA_W-1])
                area_next = sum[AREA_W] ? AREA_MIN : AREA_MAX;
            else
                area_next = sum[AREA_W-1:0];
        end

        detect = peak_seen_next && (max_mag_next > cfg.threshold);

        res_detected_next = detect;
        res_height_next   = detect ? max_mag_next : '0;
        res_voltage_next  = detect ? max_voltage_next : '0;
        res_area_next     = detect ? area_next : '0;

        if (b_take && b_data.last)
        begin
            max_mag_next     = '0;
            max_voltage_next = '0;
            peak_seen_next   = 1'b0;
            area_next        = '0;
        end

        if (b_take && b_data.last)
            res_valid_next = 1'b1;
        else if (result.ready)
            res_valid_next = 1'b0;
        else
            res_valid_next = res_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_mag_reg     <= '0;
            max_voltage_reg <= '0;
            peak_seen_reg   <= 1'b0;
            area_reg        <= '0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            if (b_take)
            begin
                max_mag_reg     <= max_mag_next;
                max_voltage_reg <= max_voltage_next;
                peak_seen_reg   <= peak_seen_next;
                area_reg        <= area_next;
            end
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_take && b_data.last)
        begin
            res_detected_reg <= res_detected_next;
            res_height_reg   <= res_height_next;
            res_voltage_reg  <= res_voltage_next;
            res_area_reg     <= res_area_next;
        end
    end

    assign result.valid        = res_valid_reg;
    assign result.detected     = res_detected_reg;
    assign result.peak_height  = res_height_reg;
    assign result.peak_voltage = res_voltage_reg;
    assign result.area_doubled = res_area_reg;

endmodule

// ----- rtl/windowed_peak_detect_with_area_unit.sv -----
// Top level of the windowed peak detector with trapezoidal area.
//
// sample: one request per scan sample (voltage in mV, signed current in nA,
//   last_sample marks the end of the scan).
// result: one request per scan, sent after the sample marked last.
// cfg: register writes (window low, window high, detection threshold); always
//   ready, to be used only while no scan is in flight.
// Throughput: one sample per cycle unless a last sample waits for the result
//   register. A sample passes an input register, the magnitude/multiply stage
//   and the accumulate stage; taking the last sample loads the result register.
// The accumulate stage can close one scan per cycle while the receiver takes each
//   result; its add-and-saturate loop on the area sum is combinational.
// When the receiver stalls, the result register holds and samples that are
//   not marked last keep flowing; a further last sample waits in the pipe.
// Reset clears the scan state and loads the register defaults (0, 250, 0).
module windowed_peak_detect_with_area_unit import wpda_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    wpda_cfg_if.sink      cfg,
    wpda_sample_if.sink   sample,
    wpda_result_if.source result
);

    cfg_t    cfg_reg, cfg_next;
    logic    a_valid_reg, a_valid_next;
    sample_t a_reg;
    logic    a_take;
    logic    in_take;
    logic    b_valid;
    logic    b_take;
    term_t   b_data;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                CFG_WINDOW_LOW:  cfg_next.window_low  = cfg.data[VOLT_W-1:0];
                CFG_WINDOW_HIGH: cfg_next.window_high = cfg.data[VOLT_W-1:0];
                CFG_THRESHOLD:   cfg_next.threshold   = cfg.data[CURR_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end

        a_take       = a_valid_reg && (!b_valid || b_take);
        sample.ready = !a_valid_reg || !b_valid || b_take;
        in_take      = sample.valid && sample.ready;

        if (in_take)
            a_valid_next = 1'b1;
        else if (a_take)
            a_valid_next = 1'b0;
        else
            a_valid_next = a_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.window_low  <= WINDOW_LOW_RESET;
            cfg_reg.window_high <= WINDOW_HIGH_RESET;
            cfg_reg.threshold   <= THRESHOLD_RESET;
            a_valid_reg         <= 1'b0;
        end
        else
        begin
            cfg_reg     <= cfg_next;
            a_valid_reg <= a_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            a_reg.voltage <= sample.sample_voltage;
            a_reg.current <= sample.sample_current;
            a_reg.last    <= sample.last_sample;
        end
    end

    wpda_front u_front
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .a_take  (a_take),
        .a_data  (a_reg),
        .b_take  (b_take),
        .b_valid (b_valid),
        .b_data  (b_data)
    );

    wpda_accum u_accum
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .b_valid (b_valid),
        .b_data  (b_data),
        .b_take  (b_take),
        .result  (result)
    );

endmodule

// ----- tb/tb_windowed_peak_detect_with_area_unit.sv -----
// Testbench for the windowed peak detector: directed table and random scans.
module tb_windowed_peak_detect_with_area_unit;
    import wpda_pkg::*;

    localparam cfg_idx_t CFG_UNUSED = 2'd3;

    localparam logic signed [VOLT_W-1:0] VOLT_MIN = {1'b1, {(VOLT_W-1){1'b0}}};
    localparam logic signed [VOLT_W-1:0] VOLT_MAX = {1'b0, {(VOLT_W-1){1'b1}}};
    localparam logic signed [CURR_W-1:0] CURR_MIN = {1'b1, {(CURR_W-1){1'b0}}};
    localparam logic signed [CURR_W-1:0] CURR_MAX = {1'b0, {(CURR_W-1){1'b1}}};

    localparam int PHASE_ITEMS = 180;
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        logic                     detected;
        logic [CURR_W-1:0]        height;
        logic signed [VOLT_W-1:0] volt;
        logic signed [AREA_W-1:0] area;
    } scan_result_t;

    typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

    typedef struct packed {
        row_kind_t                kind;
        cfg_idx_t                 idx;
        logic [CFG_DATA_W-1:0]    data;
        logic signed [VOLT_W-1:0] volt;
        logic signed [CURR_W-1:0] curr;
        logic                     last;
        logic                     known;
        logic                     want_det;
        logic [CURR_W-1:0]        want_height;
        logic signed [VOLT_W-1:0] want_volt;
        logic signed [AREA_W-1:0] want_area;
    } stim_row_t;

    // known rows carry the result expected of their scan
    localparam stim_row_t DIRECTED [36] = '{
        '{ROW_SAMPLE, CFG_WINDOW_LOW, 24'h0, 16'sd0, 24'sd0, 1'b1,
          1'b1, 1'b0, 24'd0, 16'sd0, 52'sd0},
        '{ROW_SAMPLE, CFG_WINDOW_LOW, 24'h0, 16'sd10, 24'sd100, 1'b0,
          1'b0, 1'b0, 24'd0, 16'sd0, 52'sd0},
        '{ROW_SAMPLE, CFG_WINDOW_LOW, 24'h0, 16'sd20, -24'sd300, 1'b0,
          1'b0, 1'b0, 24'd0, 16'sd0, 52'sd0},
        '{ROW_SAMPLE, CFG_WINDOW_LOW, 24'h0, 16'sd30, 24'sd300, 1'b1,
          1'b1, 1'b1, 24'd300, 16'sd20, 52'sd10000},
        '{ROW_SAMPLE, CFG_WINDOW_LOW, 24'h0, -16'sd1, 24'sd1000, 1'b0,
          1'b0, 1'b0, 24'd0, 16'sd0, 52'sd0},
        '{ROW_SAMPLE, CFG_WINDOW_LOW, 24'h0, 16'sd251, 24'sd2000, 1'b1,
          1'b1, 1'b0, 24'd0, 16'sd0, 52'sd0},
        '{ROW_SAMPLE, CFG_WINDOW_LOW, 24'h0, 16'sd0, CURR_MIN, 1'b0,
          1'b0, 1'b0, 24'd0, 16'sd0, 52'sd0},
        '{ROW_SAMPLE, CFG_WINDOW_LOW, 24'h0, 16'sd250, CURR_MIN, 1'b1,
          1'b1, 1'b1, 24'd8388608, 16'sd0, 52'sd4194304000},
        '{ROW_SAMPLE, CFG_WINDOW_LOW, 24'h0, 16'sd100, 24'sd50, 1'b0,
          1'b0, 1'b0, 24'd0, 16'sd0, 52'sd0},
        '{ROW_SAMPLE, CFG_WINDOW_LOW, 24'h0, 16'sd50, 24'sd50, 1'b1,
          1'b1, 1'b1, 24'd50, 16'sd100, -52'sd5000},
        '{ROW_WRITE, CFG_THRESHOLD, 24'd50, 16'sd0, 24'sd0, 1'b0,
          1'b0, 1'b0, 24'd0, 16'sd0, 52'sd0},
        '{ROW_WRITE, CFG_UNUSED, 24'h0, 16'sd0, 24'sd0, 1'b0,
          1'b0, 1'b0, 24'd0, 16'sd0, 52'sd0},
        '{ROW_SAMPLE, CFG_WINDOW_LOW, 24'h0, 16'sd10, 24'sd50, 1'b1,
          1'b1, 1'b0, 24'd0, 16'sd0, 52'sd0},
        '{ROW_SAMPLE, CFG_WINDOW_LOW, 24'h0, 16'sd10, -24'sd51, 1'b1,
          1'b1, 1'b1, 24'd51, 16'sd10, 52'sd0},
        '{ROW_WRITE, CFG_WINDOW_LOW, 24'd200, 16'sd0, 24'sd0, 1'b0,
          1'b0, 1'b0, 24'd0, 16'sd0, 52'sd0},
        '{ROW_WRITE, CFG_WINDOW_HIGH, 24'd100, 16'sd0, 24'sd0, 1'b0,
          1'b0, 1'b0, 24'd0, 16'sd0, 52'sd0},
        '{ROW_WRITE, CFG_THRESHOLD, 24'd0, 16'sd0, 24'sd0, 1'b0,
          1'b0, 1'b0, 24'd0, 16'sd0, 52'sd0},
        '{ROW_SAMPLE, CFG_WINDOW_LOW, 24'h0, 16'sd150, 24'sd777, 1'b0,
          1'b0, 1'b0, 24'd0, 16'sd0, 52'sd0},
        '{ROW_SAMPLE, CFG_WINDOW_LOW, 24'h0, 16'sd100, 24'sd5, 1'b1,
          1'b1, 1'b0, 24'd0, 16'sd0, 52'sd0},
        '{ROW_WRITE, CFG_UNUSED, 24'hFFFFFF, 16'sd0, 24'sd0, 1'b0,
          1'b0, 1'b0, 24'd0, 16'sd0, 52'sd0},
        '{ROW_WRITE, CFG_WINDOW_LOW, 24'hFF8000, 16'sd0, 24'sd0, 1'b0,
          1'b0, 1'b0, 24'd0, 16'sd0, 52'sd0},
        '{ROW_WRITE, CFG_WINDOW_HIGH, 24'h007FFF, 16'sd0, 24'sd0, 1'b0,
          1'b0, 1'b0, 24'd0, 16'sd0, 52'sd0},
        '{ROW_WRITE, CFG_THRESHOLD, 24'hFFFFFF, 16'sd0, 24'sd0, 1'b0,
          1'b0, 1'b0, 24'd0, 16'sd0, 52'sd0},
        '{ROW_SAMPLE, CFG_WINDOW_LOW, 24'h0, VOLT_MIN, CURR_MIN, 1'b1,
          1'b1, 1'b0, 24'd0, 16'sd0, 52'sd0},
        '{ROW_WRITE, CFG_THRESHOLD, 24'h7FFFFF, 16'sd0, 24'sd0, 1'b0,
          1'b0, 1'b0, 24'd0, 16'sd0, 52'sd0},
        '{ROW_SAMPLE, CFG_WINDOW_LOW, 24'h0, VOLT_MIN, CURR_MIN, 1'b0,
          1'b0, 1'b0, 24'd0, 16'sd0, 52'sd0},
        '{ROW_SAMPLE, CFG_WINDOW_LOW, 24'h0, VOLT_MAX, CURR_MAX, 1'b1,
          1'b0, 1'b0, 24'd0, 16'sd0, 52'sd0},
        '{ROW_SAMPLE, CFG_WINDOW_LOW, 24'h0, VOLT_MAX, CURR_MAX, 1'b1,
          1'b1, 1'b0, 24'd0, 16'sd0, 52'sd0},
        '{ROW_WRITE, CFG_THRESHOLD, 24'd0, 16'sd0, 24'sd0, 1'b0,
          1'b0, 1'b0, 24'd0, 16'sd0, 52'sd0},
        '{ROW_WRITE, CFG_WINDOW_LOW, 24'h00FFFB, 16'sd0, 24'sd0, 1'b0,
          1'b0, 1'b0, 24'd0, 16'sd0, 52'sd0},
        '{ROW_WRITE, CFG_WINDOW_HIGH, 24'h0AFFFB, 16'sd0, 24'sd0, 1'b0,
          1'b0, 1'b0, 24'd0, 16'sd0, 52'sd0},
        '{ROW_SAMPLE, CFG_WINDOW_LOW, 24'h0, -16'sd6, 24'sd9, 1'b0,
          1'b0, 1'b0, 24'd0, 16'sd0, 52'sd0},
        '{ROW_SAMPLE, CFG_WINDOW_LOW, 24'h0, -16'sd5, -24'sd9, 1'b0,
          1'b0, 1'b0, 24'd0, 16'sd0, 52'sd0},
        '{ROW_SAMPLE, CFG_WINDOW_LOW, 24'h0, -16'sd5, 24'sd9, 1'b0,
          1'b0, 1'b0, 24'd0, 16'sd0, 52'sd0},
        '{ROW_SAMPLE, CFG_WINDOW_LOW, 24'h0, -16'sd4, 24'sd100, 1'b1,
          1'b1, 1'b1, 24'd9, -16'sd5, 52'sd0},
        '{ROW_SAMPLE, CFG_WINDOW_LOW, 24'h0, -16'sd5, 24'sd0, 1'b1,
          1'b1, 1'b0, 24'd0, 16'sd0, 52'sd0}
    };

    logic clk = 1'b0;
    logic rst_n;

    wpda_cfg_if    cfg_bus ();
    wpda_sample_if sample_bus ();
    wpda_result_if result_bus ();

    windowed_peak_detect_with_area_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_bus),
        .sample (sample_bus),
        .result (result_bus)
    );

    always #2 clk = ~clk;

    // detector model: registers and scan state
    logic signed [VOLT_W-1:0] win_lo    = WINDOW_LOW_RESET;
    logic signed [VOLT_W-1:0] win_hi    = WINDOW_HIGH_RESET;
    logic [CURR_W-1:0]        floor_na  = THRESHOLD_RESET;
    logic [CURR_W-1:0]        top_mag   = '0;
    logic signed [VOLT_W-1:0] top_volt  = '0;
    logic                     found     = 1'b0;
    logic signed [VOLT_W-1:0] prev_volt = '0;
    logic [CURR_W-1:0]        prev_mag  = '0;
    logic                     in_scan   = 1'b0;
    longint                   area_sum  = 0;

    scan_result_t pending_results [$];
    scan_result_t row_want;
    logic         row_known = 1'b0;
    int           fails = 0;
    bit           steady = 1'b0;
    bit           hold_pending = 1'b0;
    int           hold_left = 0;
    int           gen_lo = 0;
    int           gen_hi = 250;

    task automatic integrate_sample(input logic signed [VOLT_W-1:0] v,
                                    input logic signed [CURR_W-1:0] c,
                                    input logic ends);
        logic [CURR_W-1:0] mag;
        longint            sum;
        scan_result_t      res;
        mag = c[CURR_W-1] ? CURR_W'(-c) : CURR_W'(c);
        if (v >= win_lo && v <= win_hi)
        begin
            if (mag > top_mag)
            begin
                top_mag  = mag;
                top_volt = v;
                found    = 1'b1;
            end
            if (in_scan)
            begin
                sum = area_sum + (longint'(mag) + longint'(prev_mag))
                               * (longint'(v) - longint'(prev_volt));
                if (sum > longint'(AREA_MAX))
                    sum = longint'(AREA_MAX);
                else if (sum < longint'(AREA_MIN))
                    sum = longint'(AREA_MIN);
                area_sum = sum;
            end
            prev_volt = v;
            prev_mag  = mag;
            in_scan   = 1'b1;
        end
        if (ends)
        begin
            res = '0;
            if (found && top_mag > floor_na)
                res = '{1'b1, top_mag, top_volt, AREA_W'(area_sum)};
            pending_results.push_back(row_known ? row_want : res);
            top_mag   = '0;
            top_volt  = '0;
            found     = 1'b0;
            prev_volt = '0;
            prev_mag  = '0;
            in_scan   = 1'b0;
            area_sum  = 0;
        end
    endtask

    always @(posedge clk)
    begin : watch
        scan_result_t got;
        scan_result_t want;
        if (result_bus.valid && result_bus.ready)
        begin
            got = '{result_bus.detected, result_bus.peak_height,
                    result_bus.peak_voltage, result_bus.area_doubled};
            if (pending_results.size() == 0)
            begin
                $error("result request with no scan outstanding");
                fails++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.detected !== want.detected)
                begin
                    $error("detected: expected %0d, got %0d", want.detected, got.detected);
                    fails++;
                end
                if (got.height !== want.height)
                begin
                    $error("peak_height: expected %0d, got %0d", want.height, got.height);
                    fails++;
                end
                if (got.volt !== want.volt)
                begin
                    $error("peak_voltage: expected %0d, got %0d", want.volt, got.volt);
                    fails++;
                end
                if (got.area !== want.area)
                begin
                    $error("area_doubled: expected %0d, got %0d", want.area, got.area);
                    fails++;
                end
            end
        end
        if (cfg_bus.valid && cfg_bus.ready)
        begin
            case (cfg_bus.index)
                CFG_WINDOW_LOW:  win_lo   = cfg_bus.data[VOLT_W-1:0];
                CFG_WINDOW_HIGH: win_hi   = cfg_bus.data[VOLT_W-1:0];
                CFG_THRESHOLD:   floor_na = cfg_bus.data;
                default: ;
            endcase
        end
        if (sample_bus.valid && sample_bus.ready)
            integrate_sample(sample_bus.sample_voltage, sample_bus.sample_current,
                             sample_bus.last_sample);
    end

    // receiver: random idling, plus one long hold-off on request
    always @(negedge clk)
    begin
        if (hold_pending)
        begin
            hold_left    = HOLD_CYCLES;
            hold_pending = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            result_bus.ready <= 1'b0;
        end
        else
            result_bus.ready <= steady || ($urandom_range(99) >= 32);
    end

    task automatic offer_sample(input logic signed [VOLT_W-1:0] v,
                                input logic signed [CURR_W-1:0] c,
                                input logic ends);
        while (!steady && $urandom_range(99) < 32)
        begin
            sample_bus.valid <= 1'b0;
            @(negedge clk);
        end
        sample_bus.valid          <= 1'b1;
        sample_bus.sample_voltage <= v;
        sample_bus.sample_current <= c;
        sample_bus.last_sample    <= ends;
        do @(posedge clk); while (!sample_bus.ready);
        @(negedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
        sample_bus.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        do @(posedge clk); while (!cfg_bus.ready);
        @(negedge clk);
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic enter_phase(input int mode);
        int                    lo;
        int                    hi;
        logic [CFG_DATA_W-1:0] nf;
        case (mode)
            0:
            begin
                lo = 0;
                hi = 250;
            end
            1:
            begin
                lo = -32768;
                hi = 32767;
            end
            2:
            begin
                lo = int'($urandom_range(0, 60000)) - 32768;
                hi = lo + int'($urandom_range(0, 2000));
                if (hi > 32767)
                    hi = 32767;
            end
            3:
            begin
                lo = int'($urandom_range(0, 1000));
                hi = lo - int'($urandom_range(1, 500));
            end
            4:
            begin
                lo = int'($urandom_range(0, 2000)) - 1000;
                hi = lo;
            end
            default:
            begin
                lo = int'(signed'(VOLT_W'($urandom)));
                hi = int'(signed'(VOLT_W'($urandom)));
            end
        endcase
        case ($urandom_range(0, 4))
            0: nf = '0;
            1: nf = CFG_DATA_W'($urandom_range(0, 300));
            2: nf = '1;
            3: nf = CFG_DATA_W'($urandom_range(0, 1 << 20));
            default: nf = CFG_DATA_W'($urandom);
        endcase
        if ($urandom_range(0, 3) == 0)
            write_reg(CFG_UNUSED, CFG_DATA_W'($urandom));
        write_reg(CFG_WINDOW_LOW, {8'($urandom), VOLT_W'(lo)});
        write_reg(CFG_WINDOW_HIGH, {8'($urandom), VOLT_W'(hi)});
        write_reg(CFG_THRESHOLD, nf);
        gen_lo = lo;
        gen_hi = hi;
    endtask

    // a sweep across the window with random currents, some ties and some noise
    task automatic run_scan(input int len);
        int k;
        int v;
        int c;
        int mag;
        int prev_abs;
        int scale;
        int stride;
        scale    = $urandom_range(0, 2);
        stride   = (gen_hi > gen_lo) ? (gen_hi - gen_lo) / len + 1 : 1;
        v        = gen_lo - int'($urandom_range(0, 2));
        prev_abs = 0;
        for (k = 0; k < len; k++)
        begin
            if (v < -32768)
                v = -32768;
            if (v > 32767)
                v = 32767;
            case (scale)
                0: mag = $urandom_range(0, 255);
                1: mag = $urandom_range(0, 65535);
                default: mag = $urandom_range(0, 8388607);
            endcase
            if ($urandom_range(0, 4) == 0)
                mag = prev_abs;
            c = $urandom_range(1) ? -mag : mag;
            if ($urandom_range(0, 9) == 0)
            begin
                case ($urandom_range(0, 2))
                    0: c = int'(CURR_MIN);
                    1: c = int'(CURR_MAX);
                    default: c = 0;
                endcase
            end
            prev_abs = (c < 0) ? -c : c;
            if ($urandom_range(0, 6) == 0)
                offer_sample(VOLT_W'($urandom), CURR_W'($urandom), k == len - 1);
            else
                offer_sample(VOLT_W'(v), CURR_W'(c), k == len - 1);
            if ($urandom_range(0, 7) == 0)
                v -= int'($urandom_range(0, stride));
            else
                v += int'($urandom_range(0, stride));
        end
    endtask

    initial
    begin
        stim_row_t r;
        int        p;
        int        done;
        int        len;
        int        n;
        rst_n                     = 1'b0;
        cfg_bus.valid             = 1'b0;
        cfg_bus.index             = CFG_WINDOW_LOW;
        cfg_bus.data              = '0;
        sample_bus.valid          = 1'b0;
        sample_bus.sample_voltage = '0;
        sample_bus.sample_current = '0;
        sample_bus.last_sample    = 1'b0;
        result_bus.ready          = 1'b0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (DIRECTED[i])
        begin
            r = DIRECTED[i];
            if (r.kind == ROW_WRITE)
                write_reg(r.idx, r.data);
            else
            begin
                row_known = r.known;
                row_want  = '{r.want_det, r.want_height, r.want_volt, r.want_area};
                offer_sample(r.volt, r.curr, r.last);
            end
        end
        row_known = 1'b0;

        for (p = 0; p < 8; p++)
        begin
            enter_phase((p < 6) ? p : p - 4);
            steady = (p == 2);
            if (p == 6)
                hold_pending = 1'b1;
            done = 0;
            while (done < PHASE_ITEMS)
            begin
                if (p == 6)
                    len = $urandom_range(1, 3);
                else if ($urandom_range(0, 9) == 0)
                    len = $urandom_range(13, 40);
                else
                    len = $urandom_range(1, 12);
                run_scan(len);
                done += len;
            end
            steady = 1'b0;
        end

        sample_bus.valid <= 1'b0;
        for (n = 0; n < 5000 && pending_results.size() != 0; n++)
            @(negedge clk);
        repeat (8) @(negedge clk);
        if (pending_results.size() != 0)
        begin
            $error("%0d scan results never arrived", pending_results.size());
            fails++;
        end
        if (fails == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("FAILURE");
        $finish;
    end

endmodule
